FILE: hdl/tpmz_pkg.sv
// tpmz_pkg: shared types and constants of the touch point median zone filter
// used by tpmz_ring and touch_point_median_zone_filter; no dependencies
package tpmz_pkg;

    localparam int COORD_W      = 8;
    localparam int TIME_W       = 32;
    localparam int SCREEN_W     = 9;
    localparam int GRACE_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DEPTH        = 3;
    localparam int CENTRE       = 120;
    localparam int INNER_R2     = 70 * 70;
    localparam int OUTER_R2     = 104 * 104;
    localparam int DIST_W       = 17;

    localparam logic [7:0]           STATUS_POINT    = 8'd1;
    localparam logic [SCREEN_W-1:0]  SCREEN_SIZE_RST = 9'd240;
    localparam logic [GRACE_W-1:0]   GRACE_TIME_RST  = 16'd30;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TIME  = 2'd1;

    typedef enum logic [2:0] {
        CALL_NONE          = 3'd0,
        CALL_PRESSED_POINT = 3'd1,
        CALL_PRESSED_BARE  = 3'd2,
        CALL_RELEASE       = 3'd3,
        CALL_CANCEL        = 3'd4
    } t_call_kind;

    typedef enum logic [1:0] {
        ZONE_CENTRE  = 2'd0,
        ZONE_RING    = 2'd1,
        ZONE_OUTSIDE = 2'd2
    } t_zone;

    typedef struct packed {
        logic                touch_active;
        logic                byte_count_ok;
        logic [7:0]          status_byte;
        logic [COORD_W-1:0]  raw_x;
        logic [COORD_W-1:0]  raw_y;
        logic [TIME_W-1:0]   now_ms;
    } t_in_word;

    typedef struct packed {
        t_call_kind          call_kind;
        logic [COORD_W-1:0]  point_x;
        logic [COORD_W-1:0]  point_y;
        t_zone               ring_zone;
        logic                panel_healthy;
        logic [TIME_W-1:0]   event_time;
    } t_out_word;

endpackage

FILE: hdl/tpmz_ring.sv
// tpmz_ring: sorts a point into a ring zone by squared distance from the centre
// depends on tpmz_pkg
module tpmz_ring (
    input  logic [tpmz_pkg::COORD_W-1:0] i_x,
    input  logic [tpmz_pkg::COORD_W-1:0] i_y,
    output tpmz_pkg::t_zone              o_zone
);

    localparam logic [tpmz_pkg::COORD_W-1:0] CTR = tpmz_pkg::COORD_W'(tpmz_pkg::CENTRE);

    logic [tpmz_pkg::COORD_W-1:0]   ax;
    logic [tpmz_pkg::COORD_W-1:0]   ay;
    logic [2*tpmz_pkg::COORD_W-1:0] sx;
    logic [2*tpmz_pkg::COORD_W-1:0] sy;
    logic [tpmz_pkg::DIST_W-1:0]    d2;

    // absolute offsets from the centre
    assign ax = (i_x >= CTR) ? (i_x - CTR) : (CTR - i_x);
    assign ay = (i_y >= CTR) ? (i_y - CTR) : (CTR - i_y);
    assign sx = ax * ax;
    assign sy = ay * ay;
    assign d2 = tpmz_pkg::DIST_W'(sx) + tpmz_pkg::DIST_W'(sy);

    always_comb begin
        priority if (d2 <= tpmz_pkg::DIST_W'(tpmz_pkg::INNER_R2)) begin
            o_zone = tpmz_pkg::ZONE_CENTRE;
        end else if (d2 <= tpmz_pkg::DIST_W'(tpmz_pkg::OUTER_R2)) begin
            o_zone = tpmz_pkg::ZONE_RING;
        end else begin
            o_zone = tpmz_pkg::ZONE_OUTSIDE;
        end
    end

endmodule

FILE: hdl/touch_point_median_zone_filter.sv
// touch_point_median_zone_filter: top level, validation, median-of-three window,
// grace handling and call generation; depends on tpmz_pkg and tpmz_ring
//
// One poll word in, one call word out. The block takes a word every cycle unless
// o_in_stall is high, and carries it through an input register, then
// one stage of validation, window update, median and ring sort feeding the output register.
// The output register decouples the sides, so a new word is taken while a finished
// call waits; i_out_stall backs up through both registers. Configuration writes are
// always ready and should be made while no word is in flight. Zone uses squared
// distance from (120,120): centre up to 70^2, ring up to 104^2, outside beyond.
module touch_point_median_zone_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tpmz_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tpmz_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tpmz_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpmz_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = tpmz_pkg::COORD_W;
    localparam int SW = $clog2(tpmz_pkg::DEPTH);
    localparam int FW = $clog2(tpmz_pkg::DEPTH + 1);

    function automatic logic [CW-1:0] mid3(input logic [CW-1:0] a,
                                           input logic [CW-1:0] b,
                                           input logic [CW-1:0] c);
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        logic [CW-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // configuration
    logic [tpmz_pkg::SCREEN_W-1:0] r_screen_size;
    logic [tpmz_pkg::GRACE_W-1:0]  r_grace_time;

    // pipeline registers
    logic                  r_in_valid;
    tpmz_pkg::t_in_word    r_in;
    logic                  r_out_valid;
    tpmz_pkg::t_out_word   r_out;

    // filter state
    logic                          r_touching;
    logic [tpmz_pkg::TIME_W-1:0]   r_last_valid;
    logic [CW-1:0]                 r_held_x;
    logic [CW-1:0]                 r_held_y;
    tpmz_pkg::t_zone               r_held_zone;
    logic [CW-1:0]                 r_win_x [tpmz_pkg::DEPTH];
    logic [CW-1:0]                 r_win_y [tpmz_pkg::DEPTH];
    logic [SW-1:0]                 r_slot;
    logic [FW-1:0]                 r_fill;
    logic                          r_healthy;

    logic                          n_touching;
    logic [tpmz_pkg::TIME_W-1:0]   n_last_valid;
    logic [CW-1:0]                 n_held_x;
    logic [CW-1:0]                 n_held_y;
    tpmz_pkg::t_zone               n_held_zone;
    logic [CW-1:0]                 n_win_x [tpmz_pkg::DEPTH];
    logic [CW-1:0]                 n_win_y [tpmz_pkg::DEPTH];
    logic [SW-1:0]                 n_slot;
    logic [FW-1:0]                 n_fill;
    logic                          n_healthy;
    tpmz_pkg::t_out_word           n_out;

    logic                          out_load;
    logic                          fire;
    logic                          read_ok;
    logic                          in_grace;
    logic [tpmz_pkg::TIME_W-1:0]   since_valid;
    logic [FW-1:0]                 fill_inc;
    logic [CW-1:0]                 filt_x;
    logic [CW-1:0]                 filt_y;
    tpmz_pkg::t_zone               filt_zone;

    assign out_load    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_load;
    assign o_in_stall  = r_in_valid && !out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    assign read_ok = r_in.byte_count_ok
                  && (r_in.status_byte == tpmz_pkg::STATUS_POINT)
                  && ({1'b0, r_in.raw_x} < r_screen_size)
                  && ({1'b0, r_in.raw_y} < r_screen_size);

    assign since_valid = r_in.now_ms - r_last_valid;
    assign in_grace    = since_valid <= tpmz_pkg::TIME_W'(r_grace_time);

    // window write and median
    always_comb begin
        n_win_x = r_win_x;
        n_win_y = r_win_y;
        n_win_x[r_slot] = r_in.raw_x;
        n_win_y[r_slot] = r_in.raw_y;
        fill_inc = (r_fill == FW'(tpmz_pkg::DEPTH)) ? r_fill : (r_fill + FW'(1));
        if (fill_inc == FW'(tpmz_pkg::DEPTH)) begin
            filt_x = mid3(n_win_x[0], n_win_x[1], n_win_x[2]);
            filt_y = mid3(n_win_y[0], n_win_y[1], n_win_y[2]);
        end else begin
            filt_x = r_in.raw_x;
            filt_y = r_in.raw_y;
        end
    end

    tpmz_ring u_ring (
        .i_x    (filt_x),
        .i_y    (filt_y),
        .o_zone (filt_zone)
    );

    always_comb begin
        n_touching   = r_touching;
        n_last_valid = r_last_valid;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_held_zone  = r_held_zone;
        n_slot       = r_slot;
        n_fill       = r_fill;
        n_healthy    = r_healthy;
        n_out        = '0;
        if (r_in.touch_active) begin
            if (!read_ok) begin
                n_healthy = 1'b0;
                if (r_touching && in_grace) begin
                    n_out.call_kind = tpmz_pkg::CALL_NONE;
                end else if (r_touching) begin
                    n_touching       = 1'b0;
                    n_fill           = '0;
                    n_out.call_kind  = tpmz_pkg::CALL_CANCEL;
                    n_out.point_x    = r_held_x;
                    n_out.point_y    = r_held_y;
                    n_out.event_time = r_in.now_ms;
                end else begin
                    n_out.call_kind  = tpmz_pkg::CALL_PRESSED_BARE;
                    n_out.event_time = r_in.now_ms;
                end
            end else begin
                n_healthy        = 1'b1;
                n_last_valid     = r_in.now_ms;
                n_slot           = (r_slot == SW'(tpmz_pkg::DEPTH - 1)) ? '0 : r_slot + SW'(1);
                n_fill           = fill_inc;
                n_held_x         = filt_x;
                n_held_y         = filt_y;
                n_held_zone      = filt_zone;
                n_touching       = 1'b1;
                n_out.call_kind  = tpmz_pkg::CALL_PRESSED_POINT;
                n_out.point_x    = filt_x;
                n_out.point_y    = filt_y;
                n_out.ring_zone  = filt_zone;
                n_out.event_time = r_in.now_ms;
            end
        end else if (r_touching) begin
            n_touching       = 1'b0;
            n_fill           = '0;
            n_out.call_kind  = tpmz_pkg::CALL_RELEASE;
            n_out.point_x    = r_held_x;
            n_out.point_y    = r_held_y;
            n_out.ring_zone  = r_held_zone;
            n_out.event_time = r_in.now_ms;
        end
        n_out.panel_healthy = n_healthy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_size <= tpmz_pkg::SCREEN_SIZE_RST;
            r_grace_time  <= tpmz_pkg::GRACE_TIME_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpmz_pkg::REG_SCREEN_SIZE: begin
                    r_screen_size <= i_cfg_data[tpmz_pkg::SCREEN_W-1:0];
                end
                tpmz_pkg::REG_GRACE_TIME: begin
                    r_grace_time <= i_cfg_data[tpmz_pkg::GRACE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (fire) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_touching   <= 1'b0;
            r_last_valid <= '0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_zone  <= tpmz_pkg::ZONE_OUTSIDE;
            r_win_x      <= '{default: '0};
            r_win_y      <= '{default: '0};
            r_slot       <= '0;
            r_fill       <= '0;
            r_healthy    <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_touching   <= n_touching;
                r_last_valid <= n_last_valid;
                r_held_x     <= n_held_x;
                r_held_y     <= n_held_y;
                r_held_zone  <= n_held_zone;
                if (r_in.touch_active && read_ok) begin
                    r_win_x <= n_win_x;
                    r_win_y <= n_win_y;
                end
                r_slot       <= n_slot;
                r_fill       <= n_fill;
                r_healthy    <= n_healthy;
            end
        end
    end

    // window slot stays inside the window
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != SW'(tpmz_pkg::DEPTH))
        else $error("window slot out of range");

    // a point call always reports a healthy panel
    a_point_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.call_kind == tpmz_pkg::CALL_PRESSED_POINT)
            |-> r_out.panel_healthy)
        else $error("point call with unhealthy panel");

    // release or cancel ends the gesture and empties the window
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (n_out.call_kind == tpmz_pkg::CALL_RELEASE
               || n_out.call_kind == tpmz_pkg::CALL_CANCEL))
            |=> (!r_touching && r_fill == '0))
        else $error("gesture end did not clear state");

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    // a point call means the block is now in a gesture
    a_point_touching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_out.call_kind == tpmz_pkg::CALL_PRESSED_POINT) |=> r_touching)
        else $error("point call left block idle");

endmodule
